>>> hdl/mexp_pkg.sv
package mexp_pkg;

  localparam int unsigned CfgIdxBits = 2;

  typedef logic [CfgIdxBits-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_MODULUS     = 2'd0;
  localparam cfg_idx_t CFG_PUBLIC_EXP  = 2'd1;
  localparam cfg_idx_t CFG_PRIVATE_EXP = 2'd2;

endpackage

>>> hdl/mexp_mulmod.sv
module mexp_mulmod #(
  parameter int unsigned WORD_BITS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [WORD_BITS-1:0] a_i,
  input  logic [WORD_BITS-1:0] b_i,
  input  logic [WORD_BITS-1:0] n_i,
  output logic                 busy_o,
  output logic                 done_o,
  output logic [WORD_BITS-1:0] prod_o
);

  localparam int unsigned SumBits = WORD_BITS + 3;
  localparam int unsigned CntBits = $clog2(WORD_BITS);

  logic [WORD_BITS-1:0] acc_q, acc_d;
  logic [WORD_BITS-1:0] a_q;
  logic [WORD_BITS-1:0] b_q;
  logic [CntBits-1:0]   cnt_q;
  logic                 busy_q;
  logic                 done_q;

  logic [SumBits-1:0] sum;
  logic [SumBits-1:0] less_n;
  logic [SumBits-1:0] less_2n;

  // one bit of b per cycle, msb first: acc = 2*acc + bit*a, reduced by n or 2n
  always_comb begin
    sum     = {2'b00, acc_q, 1'b0} + (b_q[WORD_BITS-1] ? {3'b000, a_q} : '0);
    less_n  = sum - {3'b000, n_i};
    less_2n = sum - {2'b00, n_i, 1'b0};
    if (!less_2n[SumBits-1]) begin
      acc_d = less_2n[WORD_BITS-1:0];
    end else if (!less_n[SumBits-1]) begin
      acc_d = less_n[WORD_BITS-1:0];
    end else begin
      acc_d = sum[WORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntBits'(WORD_BITS - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      a_q   <= a_i;
      b_q   <= b_i;
    end else if (busy_q) begin
      acc_q <= acc_d;
      b_q   <= {b_q[WORD_BITS-2:0], 1'b0};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign prod_o = acc_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("multiplier started while busy");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> done_q)
    else $error("multiplier finished without done");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("done held longer than one cycle");

endmodule

>>> hdl/modular_exponentiation_top.sv
// Modular exponentiation by right-to-left square-and-multiply. Each accepted word
// (mode, message) yields one power_result word: message raised to the public
// exponent (mode 0) or private exponent (mode 1), modulo the modulus; a modulus of
// 0 or 1 gives 0. Registers are written through the cfg port (index 0 modulus,
// 1 public exponent, 2 private exponent, others ignored); the user must write them
// only while the block is idle, as the block itself does not enforce this.
// All work runs on one shared bit-serial modular multiplier. An item takes one
// product to reduce the message, then for each exponent bit up to the highest set
// bit a check, one multiply when the bit is set and one squaring, then a final
// check and a finish step; a modulus below 2 goes from accept straight to the
// finish step. The finish state repeats while the previous result still waits,
// stalled, in the output register. One item is worked on at a time; the next is
// taken while the finished result waits in the output register.
module modular_exponentiation_top #(
  parameter int unsigned WORD_BITS = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    mode_i,
  input  logic [WORD_BITS-1:0]    message_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [WORD_BITS-1:0]    power_result_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  mexp_pkg::cfg_idx_t      cfg_index_i,
  input  logic [WORD_BITS-1:0]    cfg_data_i
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_REDUCE = 3'd1;
  localparam logic [2:0] ST_CHECK  = 3'd2;
  localparam logic [2:0] ST_MUL    = 3'd3;
  localparam logic [2:0] ST_SQR    = 3'd4;
  localparam logic [2:0] ST_FIN    = 3'd5;

  logic [WORD_BITS-1:0] modulus_q, public_exp_q, private_exp_q;
  logic [2:0]           state_q, state_d;
  logic [WORD_BITS-1:0] exp_q, exp_d;
  logic [WORD_BITS-1:0] base_q, base_d;
  logic [WORD_BITS-1:0] acc_q, acc_d;
  logic                 out_valid_q, out_valid_d;
  logic [WORD_BITS-1:0] result_q, result_d;

  logic                 mm_start;
  logic [WORD_BITS-1:0] mm_a, mm_b;
  logic                 mm_busy;
  logic                 mm_done;
  logic [WORD_BITS-1:0] mm_prod;

  logic in_accept;
  logic mod_small;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && (state_q == ST_IDLE);
  assign mod_small   = (modulus_q[WORD_BITS-1:1] == '0);
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q     <= WORD_BITS'(1);
      public_exp_q  <= WORD_BITS'(1);
      private_exp_q <= WORD_BITS'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        mexp_pkg::CFG_MODULUS:     modulus_q     <= cfg_data_i;
        mexp_pkg::CFG_PUBLIC_EXP:  public_exp_q  <= cfg_data_i;
        mexp_pkg::CFG_PRIVATE_EXP: private_exp_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    exp_d       = exp_q;
    base_d      = base_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q;
    result_d    = result_q;
    mm_start    = 1'b0;
    mm_a        = base_q;
    mm_b        = base_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          exp_d = mode_i ? private_exp_q : public_exp_q;
          if (mod_small) begin
            acc_d   = '0;
            state_d = ST_FIN;
          end else begin
            acc_d    = WORD_BITS'(1);
            mm_start = 1'b1;
            mm_a     = WORD_BITS'(1);
            mm_b     = message_i;
            state_d  = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        if (mm_done) begin
          base_d  = mm_prod;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (exp_q == '0) begin
          state_d = ST_FIN;
        end else if (exp_q[0]) begin
          mm_start = 1'b1;
          mm_a     = acc_q;
          mm_b     = base_q;
          state_d  = ST_MUL;
        end else begin
          mm_start = 1'b1;
          state_d  = ST_SQR;
        end
      end
      ST_MUL: begin
        if (mm_done) begin
          acc_d    = mm_prod;
          mm_start = 1'b1;
          state_d  = ST_SQR;
        end
      end
      ST_SQR: begin
        if (mm_done) begin
          base_d  = mm_prod;
          exp_d   = {1'b0, exp_q[WORD_BITS-1:1]};
          state_d = ST_CHECK;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          result_d    = acc_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    exp_q    <= exp_d;
    base_q   <= base_d;
    acc_q    <= acc_d;
    result_q <= result_d;
  end

  mexp_mulmod #(
    .WORD_BITS(WORD_BITS)
  ) u_mulmod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mm_start),
    .a_i    (mm_a),
    .b_i    (mm_b),
    .n_i    (modulus_q),
    .busy_o (mm_busy),
    .done_o (mm_done),
    .prod_o (mm_prod)
  );

  assign out_valid_o    = out_valid_q;
  assign power_result_o = result_q;

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q != ST_IDLE)
    else $error("accepted word did not start work");

  a_check_unit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHECK || state_q == ST_FIN || state_q == ST_IDLE) |-> !mm_busy)
    else $error("multiplier busy outside a product state");

  a_fin_loads_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && !(out_valid_q && out_stall_i)) |=> out_valid_q)
    else $error("finished word not presented");

endmodule
